>>> rtl/mcs_pkg.sv
// Shared types and constants of the methylation call statistics block.
`default_nettype none
package mcs_pkg;

  localparam int TABLE_DEPTH_DEF = 64;
  localparam int KEY_WIDTH_DEF   = 16;
  localparam int NUM_TABLES      = 4;
  localparam int NUM_COUNTERS    = 12;
  localparam int CFG_DATA_W      = 16;
  localparam int CFG_IDX_W       = 2;

  localparam logic [15:0] LOW_THR_RST  = 16'd9830;
  localparam logic [15:0] HIGH_THR_RST = 16'd22938;
  localparam logic [7:0]  QUAL_THR_RST = 8'd20;

  typedef enum logic [1:0] {
    ACT_ADD   = 2'd0,
    ACT_RDCNT = 2'd1,
    ACT_RDTAB = 2'd2
  } mcs_action_e;

  typedef enum logic [1:0] {
    ST_DONE = 2'd0,
    ST_SKIP = 2'd1,
    ST_FULL = 2'd2,
    ST_BAD  = 2'd3
  } mcs_status_e;

  typedef enum logic [1:0] {
    CFG_LOW  = 2'd0,
    CFG_HIGH = 2'd1,
    CFG_QUAL = 2'd2
  } mcs_cfg_e;

  typedef struct packed {
    logic [1:0]  action;
    logic        has_contig;
    logic        has_value;
    logic        contexts_match;
    logic        reference_is_cg;
    logic [15:0] meth_level;
    logic [7:0]  phred_quality;
    logic [15:0] info_reads;
    logic [5:0]  read_index;
    logic [1:0]  table_select;
  } mcs_in_t;

  typedef struct packed {
    mcs_status_e status;
    logic [31:0] counter_value;
    logic [15:0] entry_key;
    logic [31:0] entry_count;
    logic        entry_valid;
    logic [6:0]  table_entries;
  } mcs_out_t;

endpackage
`default_nettype wire

>>> rtl/mcs_if.sv
// Valid/ready stream interfaces for record beats and result beats.
`default_nettype none
interface mcs_in_if;
  import mcs_pkg::*;
  logic    valid;
  logic    ready;
  mcs_in_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface mcs_out_if;
  import mcs_pkg::*;
  logic     valid;
  logic     ready;
  mcs_out_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

>>> rtl/methylation_call_statistics.sv
// Methylation call statistics: class counters in registers, key-count tables in one memory.
//
// One record or read request is taken at a time; a result beat waits in an output
// register while the next beat is taken. An added record scans its all-quality
// table and, for a high-quality call, its high-quality table, through the single
// read port of the table memory at one entry a cycle. Table contents are undefined
// after reset; the fill counts are cleared, so no clearing pass is run.
`default_nettype none
module methylation_call_statistics #(
  parameter int TABLE_DEPTH = mcs_pkg::TABLE_DEPTH_DEF,
  parameter int KEY_WIDTH   = mcs_pkg::KEY_WIDTH_DEF
) (
  input  wire                             clk_i,
  input  wire                             rst_ni,
  input  wire                             cfg_we_i,
  input  wire [mcs_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  wire [mcs_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  mcs_in_if.sink                          in_i,
  mcs_out_if.source                       out_o
);
  import mcs_pkg::*;

  localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int FW = $clog2(TABLE_DEPTH + 1);
  localparam int AW = 2 + IW;
  localparam int MW = KEY_WIDTH + 32;
  localparam int MEM_DEPTH = NUM_TABLES * (2 ** IW);
  localparam logic [FW-1:0] DEPTH_F = FW'(TABLE_DEPTH);

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_RD, S_DONE} state_e;

  state_e          state_q;
  logic [15:0]     low_thr_q, high_thr_q;
  logic [7:0]      qual_thr_q;
  logic [31:0]     cnt_q [NUM_COUNTERS];
  logic [FW-1:0]   fill_q [NUM_TABLES];
  logic [1:0]      tbl_q;
  logic            second_q;
  logic            full_q;
  logic [KEY_WIDTH-1:0] key_q;
  logic [FW-1:0]   scan_idx_q;
  logic            rd_vld_q;
  logic [IW-1:0]   rd_idx_q;
  mcs_out_t        res_q;
  logic            out_vld_q;
  mcs_out_t        out_data_q;

  logic [MW-1:0]   mem [MEM_DEPTH];
  logic [MW-1:0]   mem_rd_q;

  mcs_in_t         din;
  logic            in_fire;
  logic [1:0]      fill_sel;
  logic [FW-1:0]   fill_cur;
  logic [FW+5:0]   idx_ext, fill_ext;
  logic            idx_bad, idx_in_fill;
  logic [6:0]      entries_out;
  logic [KEY_WIDTH+15:0] key_ext, ek_ext;
  logic [KEY_WIDTH-1:0]  key_in, rd_key;
  logic [31:0]     rd_cnt, rd_cnt_inc;
  logic [1:0]      lv;
  logic            hq;
  logic [3:0]      ci;
  logic            hit, issue, miss_end, full_now, tbl_end;
  logic            mem_we, mem_re;
  logic [AW-1:0]   mem_wa, mem_ra;
  logic [MW-1:0]   mem_wd;

  assign din     = in_i.data;
  assign in_i.ready = (state_q == S_IDLE);
  assign in_fire = in_i.valid && in_i.ready;
  assign out_o.valid = out_vld_q;
  assign out_o.data  = out_data_q;

  assign fill_sel = (state_q == S_SCAN) ? tbl_q : din.table_select;
  assign fill_cur = fill_q[fill_sel];

  assign idx_ext     = {{FW{1'b0}}, din.read_index};
  assign fill_ext    = {6'b0, fill_cur};
  assign idx_bad     = (idx_ext >= (FW + 6)'(TABLE_DEPTH));
  assign idx_in_fill = (idx_ext < fill_ext);
  assign entries_out = fill_ext[6:0];

  assign key_ext = {{KEY_WIDTH{1'b0}}, din.info_reads};
  assign key_in  = key_ext[KEY_WIDTH-1:0];
  assign rd_key  = mem_rd_q[MW-1:32];
  assign rd_cnt  = mem_rd_q[31:0];
  assign ek_ext  = {16'b0, rd_key};
  assign rd_cnt_inc = (rd_cnt == 32'hFFFF_FFFF) ? rd_cnt : rd_cnt + 32'd1;

  always_comb begin
    if (din.meth_level <= low_thr_q) begin
      lv = 2'd0;
    end else if (din.meth_level <= high_thr_q) begin
      lv = 2'd1;
    end else begin
      lv = 2'd2;
    end
    hq = (din.phred_quality >= qual_thr_q);
    ci = (din.contexts_match ? 4'd0 : 4'd6) + {1'b0, lv, 1'b0} + {3'b0, hq};
  end

  // search: one read issued per cycle, compared in the next cycle
  assign hit      = (state_q == S_SCAN) && rd_vld_q && (rd_key == key_q);
  assign issue    = (state_q == S_SCAN) && !hit && (scan_idx_q < fill_cur);
  assign miss_end = (state_q == S_SCAN) && !hit && (scan_idx_q == fill_cur);
  assign full_now = miss_end && (fill_cur == DEPTH_F);
  assign tbl_end  = hit || miss_end;

  always_comb begin
    mem_we = 1'b0;
    mem_wa = {tbl_q, rd_idx_q};
    mem_wd = {key_q, rd_cnt_inc};
    if (hit) begin
      mem_we = 1'b1;
    end else if (miss_end && !full_now) begin
      mem_we = 1'b1;
      mem_wa = {tbl_q, fill_cur[IW-1:0]};
      mem_wd = {key_q, 32'd1};
    end
    if (state_q == S_SCAN) begin
      mem_re = issue;
      mem_ra = {tbl_q, scan_idx_q[IW-1:0]};
    end else begin
      mem_re = in_fire && (din.action == ACT_RDTAB) && !idx_bad && idx_in_fill;
      mem_ra = {din.table_select, idx_ext[IW-1:0]};
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      mem_rd_q <= mem[mem_ra];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      low_thr_q  <= LOW_THR_RST;
      high_thr_q <= HIGH_THR_RST;
      qual_thr_q <= QUAL_THR_RST;
      for (int i = 0; i < NUM_COUNTERS; i++) cnt_q[i] <= '0;
      for (int i = 0; i < NUM_TABLES; i++) fill_q[i] <= '0;
      tbl_q      <= '0;
      second_q   <= 1'b0;
      full_q     <= 1'b0;
      key_q      <= '0;
      scan_idx_q <= '0;
      rd_vld_q   <= 1'b0;
      rd_idx_q   <= '0;
      res_q      <= '0;
      out_vld_q  <= 1'b0;
      out_data_q <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_LOW:  low_thr_q  <= cfg_data_i;
          CFG_HIGH: high_thr_q <= cfg_data_i;
          CFG_QUAL: qual_thr_q <= cfg_data_i[7:0];
          default: ;
        endcase
      end
      if (out_vld_q && out_o.ready) begin
        out_vld_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_fire) begin
            res_q <= '0;
            state_q <= S_DONE;
            case (din.action)
              ACT_ADD: begin
                if (!din.has_contig || !din.has_value) begin
                  res_q.status <= ST_SKIP;
                end else begin
                  if (cnt_q[ci] != 32'hFFFF_FFFF) begin
                    cnt_q[ci] <= cnt_q[ci] + 32'd1;
                  end
                  tbl_q      <= {1'b0, !(din.contexts_match && din.reference_is_cg)};
                  second_q   <= hq;
                  full_q     <= 1'b0;
                  key_q      <= key_in;
                  scan_idx_q <= '0;
                  rd_vld_q   <= 1'b0;
                  state_q    <= S_SCAN;
                end
              end
              ACT_RDCNT: begin
                if (din.read_index < 6'(NUM_COUNTERS)) begin
                  res_q.counter_value <= cnt_q[din.read_index[3:0]];
                end else begin
                  res_q.status <= ST_BAD;
                end
              end
              ACT_RDTAB: begin
                res_q.table_entries <= entries_out;
                if (idx_bad) begin
                  res_q.status <= ST_BAD;
                end else if (idx_in_fill) begin
                  state_q <= S_RD;
                end
              end
              default: res_q.status <= ST_BAD;
            endcase
          end
        end
        S_SCAN: begin
          rd_vld_q <= issue;
          if (issue) begin
            scan_idx_q <= scan_idx_q + FW'(1);
            rd_idx_q   <= scan_idx_q[IW-1:0];
          end
          if (miss_end) begin
            if (full_now) begin
              full_q <= 1'b1;
            end else begin
              fill_q[tbl_q] <= fill_cur + FW'(1);
            end
          end
          if (tbl_end) begin
            rd_vld_q <= 1'b0;
            if (second_q) begin
              second_q   <= 1'b0;
              tbl_q      <= {1'b1, tbl_q[0]};
              scan_idx_q <= '0;
            end else begin
              res_q.status <= (full_q || full_now) ? ST_FULL : ST_DONE;
              state_q <= S_DONE;
            end
          end
        end
        S_RD: begin
          res_q.entry_valid <= 1'b1;
          res_q.entry_key   <= ek_ext[15:0];
          res_q.entry_count <= rd_cnt;
          state_q <= S_DONE;
        end
        S_DONE: begin
          if (!out_vld_q || out_o.ready) begin
            out_data_q <= res_q;
            out_vld_q  <= 1'b1;
            state_q    <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_cur <= DEPTH_F)
    else $error("table fill above depth");

  a_we_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> (state_q == S_SCAN))
    else $error("table write outside a search");

  a_rdvld_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_vld_q |-> (state_q == S_SCAN))
    else $error("search read pending outside a search");

  a_result_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_vld_q) |-> $past(state_q == S_DONE))
    else $error("result beat raised without a finished item");

endmodule
`default_nettype wire
